FILE: sv/lru_writeback_cache_stream_prefetch_assert.svh
// assertion helpers for the cache modules, included by lwcsp_back
`ifndef LRU_WRITEBACK_CACHE_STREAM_PREFETCH_ASSERT_SVH
`define LRU_WRITEBACK_CACHE_STREAM_PREFETCH_ASSERT_SVH

// same-cycle implication
`define LWCSP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lwcsp same-cycle check failed");

// next-cycle implication
`define LWCSP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lwcsp next-cycle check failed");

`endif

FILE: sv/lwcsp_pkg.sv
`default_nettype none
package lwcsp_pkg;

   localparam int SET_MAX_W = 12;

   typedef struct packed {
      logic [2:0] bo;
      logic [3:0] ib;
      logic [2:0] ways;
      logic [2:0] streams;
      logic [2:0] depth;
   } cfg_type;

   typedef struct packed {
      logic                 wr;
      logic [SET_MAX_W-1:0] set;
      logic [29:0]          tag;
      logic [31:0]          blk;
   } item_type;

   typedef enum logic [1:0] {
      KIND_WB       = 2'd0,
      KIND_DEMAND   = 2'd1,
      KIND_PREFETCH = 2'd2,
      KIND_DONE     = 2'd3
   } kind_type;

   localparam logic [2:0] REG_BO      = 3'd0;
   localparam logic [2:0] REG_IB      = 3'd1;
   localparam logic [2:0] REG_WAYS    = 3'd2;
   localparam logic [2:0] REG_STREAMS = 3'd3;
   localparam logic [2:0] REG_DEPTH   = 3'd4;

endpackage
`default_nettype wire

FILE: sv/lwcsp_queue.sv
`default_nettype none
module lwcsp_queue
   import lwcsp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   input  wire item_type push_data,
   output logic          push_ready,
   output logic          pop_valid,
   output item_type      pop_data,
   input  wire logic     pop_ready
);

   item_type   slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wptr_in  = do_push ? !wptr_ff : wptr_ff;
      rptr_in  = do_pop ? !rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: sv/lwcsp_front.sv
`default_nettype none
module lwcsp_front
   import lwcsp_pkg::*;
#(
   parameter int SETS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        hold,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic        req_action,
   input  wire logic [31:0] req_address,
   output logic             push_valid,
   output item_type         push_data,
   input  wire logic        push_ready
);

   localparam logic [16:0] RECIP  = 17'(65536 / SETS);
   localparam logic [15:0] SETS16 = 16'(SETS);

   typedef enum logic [3:0] {
      F_IDLE  = 4'b0001,
      F_MUL   = 4'b0010,
      F_SCALE = 4'b0100,
      F_PUSH  = 4'b1000
   } fstate_type;

   fstate_type  state_ff, state_in;
   logic [31:0] addr_ff, addr_in;
   logic        wr_ff, wr_in;
   logic [31:0] prod_ff, prod_in;
   logic [27:0] qs_ff, qs_in;

   logic [31:0] shifted;
   logic [14:0] mask;
   logic [14:0] x;
   logic [15:0] r_full, r_red;
   logic [4:0]  tag_sh;

   assign shifted = addr_ff >> cfg.bo;
   assign mask    = 15'((17'd1 << cfg.ib) - 17'd1);
   assign x       = shifted[14:0] & mask;
   // set index modulo SETS via reciprocal, quotient may come out one low
   assign r_full  = 16'(x) - 16'(qs_ff);
   assign r_red   = (r_full >= SETS16) ? (r_full - SETS16) : r_full;
   assign tag_sh  = 5'(cfg.bo) + 5'(cfg.ib);

   assign req_tready     = (state_ff == F_IDLE) && !hold;
   assign push_valid     = (state_ff == F_PUSH);
   assign push_data.wr   = wr_ff;
   assign push_data.set  = r_red[SET_MAX_W-1:0];
   assign push_data.tag  = 30'(addr_ff >> tag_sh);
   assign push_data.blk  = (addr_ff >> cfg.bo) << cfg.bo;

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      wr_in    = wr_ff;
      prod_in  = prod_ff;
      qs_in    = qs_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_tvalid && req_tready) begin
               addr_in  = req_address;
               wr_in    = req_action;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            prod_in  = 32'(x) * 32'(RECIP);
            state_in = F_SCALE;
         end
         F_SCALE: begin
            qs_in    = 28'(prod_ff[30:16]) * 28'(SETS);
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      wr_ff   <= wr_in;
      prod_ff <= prod_in;
      qs_ff   <= qs_in;
   end

endmodule
`default_nettype wire

FILE: sv/lwcsp_back.sv
`default_nettype none
`include "lru_writeback_cache_stream_prefetch_assert.svh"
module lwcsp_back
   import lwcsp_pkg::*;
#(
   parameter int SETS         = 256,
   parameter int WAYS         = 4,
   parameter int STREAMS      = 4,
   parameter int STREAM_DEPTH = 4
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     pop_valid,
   input  wire item_type pop_data,
   output logic          pop_ready,
   output logic          clearing,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output kind_type      rsp_kind,
   output logic [31:0]   rsp_address,
   output logic          rsp_cache_hit,
   output logic          rsp_stream_hit,
   output logic          rsp_last
);

   localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SB_W   = (STREAMS > 1) ? $clog2(STREAMS) : 1;
   localparam int DE_W   = (STREAM_DEPTH > 1) ? $clog2(STREAM_DEPTH) : 1;
   localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

   typedef struct packed {
      logic [WAYS-1:0][29:0]      tag;
      logic [WAYS-1:0][31:0]      blk;
      logic [WAYS-1:0]            valid;
      logic [WAYS-1:0]            dirty;
      logic [WAYS-1:0][WAY_W-1:0] age;
   } row_type;

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_EVAL  = 9'b000000100,
      ST_INV   = 9'b000001000,
      ST_SLOOK = 9'b000010000,
      ST_WB    = 9'b000100000,
      ST_DEM   = 9'b001000000,
      ST_PF    = 9'b010000000,
      ST_DONE  = 9'b100000000
   } bstate_type;

   row_type row_mem [SETS];
   row_type rd_ff;

   bstate_type       state_ff, state_in;
   logic [SET_W-1:0] clr_ff, clr_in;
   item_type         item_ff, item_in;
   logic             hit_ff, hit_in;
   logic             wb_ff, wb_in;
   logic [31:0]      va_ff, va_in;
   logic             shit_ff, shit_in;
   logic [31:0]      pf_num_ff, pf_num_in;
   logic [4:0]       pf_cnt_ff, pf_cnt_in;
   logic [4:0]       pf_e_ff, pf_e_in;

   logic [31:0]     sa_ff   [STREAMS][STREAM_DEPTH];
   logic [31:0]     sa_in   [STREAMS][STREAM_DEPTH];
   logic            sv_ff   [STREAMS][STREAM_DEPTH];
   logic            sv_in   [STREAMS][STREAM_DEPTH];
   logic [SB_W-1:0] sage_ff [STREAMS];
   logic [SB_W-1:0] sage_in [STREAMS];

   logic        out_valid_ff, out_valid_in;
   kind_type    out_kind_ff, out_kind_in;
   logic [31:0] out_addr_ff, out_addr_in;
   logic        out_ch_ff, out_ch_in;
   logic        out_sh_ff, out_sh_in;
   logic        out_last_ff, out_last_in;

   logic [4:0] nw, ns, nd;
   logic       pf;
   logic       out_free;
   logic       need_dem;

   logic             mem_we;
   logic [SET_W-1:0] mem_waddr;
   row_type          mem_wdata;
   row_type          reset_row;
   row_type          new_row;
   logic             hit;
   logic [WAY_W-1:0] hit_way, victim, way_sel;
   logic [WAY_W-1:0] vic_age, t_age;

   assign nw = (cfg.ways == 3'd0) ? 5'd1 :
               ((5'(cfg.ways) > 5'(WAYS)) ? 5'(WAYS) : 5'(cfg.ways));
   assign ns = (5'(cfg.streams) > 5'(STREAMS)) ? 5'(STREAMS) : 5'(cfg.streams);
   assign nd = (5'(cfg.depth) > 5'(STREAM_DEPTH)) ? 5'(STREAM_DEPTH) : 5'(cfg.depth);
   assign pf = (ns != 5'd0) && (nd != 5'd0);

   assign out_free  = !out_valid_ff || rsp_ready;
   assign need_dem  = !hit_ff && !shit_ff;
   assign pop_ready = (state_ff == ST_IDLE);
   assign clearing  = (state_ff == ST_CLEAR);

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_address    = out_addr_ff;
   assign rsp_cache_hit  = out_ch_ff;
   assign rsp_stream_hit = out_sh_ff;
   assign rsp_last       = out_last_ff;

   always_comb begin
      reset_row = '0;
      for (int w = 0; w < WAYS; w++) begin
         reset_row.age[w] = WAY_W'(w);
      end
   end

   // tag compare, lru victim and updated row for the set just read
   always_comb begin
      logic have;
      hit     = 1'b0;
      hit_way = '0;
      victim  = '0;
      vic_age = '0;
      have    = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         if (5'(w) < nw) begin
            if (!hit && rd_ff.valid[w] && (rd_ff.tag[w] == item_ff.tag)) begin
               hit     = 1'b1;
               hit_way = WAY_W'(w);
            end
            if (!have || (rd_ff.age[w] > vic_age)) begin
               have    = 1'b1;
               vic_age = rd_ff.age[w];
               victim  = WAY_W'(w);
            end
         end
      end
      way_sel = hit ? hit_way : victim;
      t_age   = rd_ff.age[way_sel];
      new_row = rd_ff;
      for (int w = 0; w < WAYS; w++) begin
         if ((5'(w) < nw) && (rd_ff.age[w] < t_age)) begin
            new_row.age[w] = rd_ff.age[w] + WAY_W'(1);
         end
      end
      new_row.age[way_sel]   = '0;
      new_row.valid[way_sel] = 1'b1;
      new_row.tag[way_sel]   = item_ff.tag;
      new_row.blk[way_sel]   = item_ff.blk;
      new_row.dirty[way_sel] = hit ? (rd_ff.dirty[way_sel] | item_ff.wr) : item_ff.wr;
   end

   always_comb begin
      logic            found;
      logic            have;
      logic [SB_W-1:0] sb;
      logic [SB_W-1:0] best;
      logic [SB_W-1:0] st;
      logic [31:0]     num;
      state_in     = state_ff;
      clr_in       = clr_ff;
      item_in      = item_ff;
      hit_in       = hit_ff;
      wb_in        = wb_ff;
      va_in        = va_ff;
      shit_in      = shit_ff;
      pf_num_in    = pf_num_ff;
      pf_cnt_in    = pf_cnt_ff;
      pf_e_in      = pf_e_ff;
      sa_in        = sa_ff;
      sv_in        = sv_ff;
      sage_in      = sage_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_kind_in  = out_kind_ff;
      out_addr_in  = out_addr_ff;
      out_ch_in    = out_ch_ff;
      out_sh_in    = out_sh_ff;
      out_last_in  = out_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = item_ff.set[SET_W-1:0];
      mem_wdata    = new_row;
      found        = 1'b0;
      have         = 1'b0;
      sb           = '0;
      best         = '0;
      st           = '0;
      num          = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = reset_row;
            if (clr_ff == LAST_SET) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + SET_W'(1);
            end
         end
         ST_IDLE: begin
            if (pop_valid) begin
               item_in  = pop_data;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            mem_we   = 1'b1;
            hit_in   = hit;
            wb_in    = !hit && rd_ff.dirty[victim];
            va_in    = (rd_ff.blk[victim] >> cfg.bo) << cfg.bo;
            state_in = ST_INV;
         end
         ST_INV: begin
            // drop stream entries holding the evicted block when it is written back
            if (wb_ff) begin
               for (int b = 0; b < STREAMS; b++) begin
                  for (int e = 0; e < STREAM_DEPTH; e++) begin
                     if ((5'(b) < ns) && (5'(e) < nd) && (sa_ff[b][e] == va_ff)) begin
                        sv_in[b][e] = 1'b0;
                     end
                  end
               end
            end
            state_in = ST_SLOOK;
         end
         ST_SLOOK: begin
            shit_in   = 1'b0;
            pf_cnt_in = 5'd0;
            pf_e_in   = 5'd1;
            if (!hit_ff && pf) begin
               for (int b = 0; b < STREAMS; b++) begin
                  if (!found && (5'(b) < ns) && sv_ff[b][0] &&
                      (sa_ff[b][0] == item_ff.blk)) begin
                     found = 1'b1;
                     sb    = SB_W'(b);
                  end
               end
               if (found) begin
                  num = sa_ff[sb][DE_W'(nd - 5'd1)] >> cfg.bo;
                  for (int e = 0; e < STREAM_DEPTH - 1; e++) begin
                     if (5'(e) + 5'd1 < nd) begin
                        sa_in[sb][e] = sa_ff[sb][e+1];
                        sv_in[sb][e] = sv_ff[sb][e+1];
                     end
                  end
                  sa_in[sb][DE_W'(nd - 5'd1)] = (num + 32'd1) << cfg.bo;
                  sv_in[sb][DE_W'(nd - 5'd1)] = 1'b1;
                  pf_cnt_in = 5'd1;
               end else begin
                  for (int b = 0; b < STREAMS; b++) begin
                     if ((5'(b) < ns) && (!have || (sage_ff[b] > best))) begin
                        have = 1'b1;
                        best = sage_ff[b];
                        sb   = SB_W'(b);
                     end
                  end
                  num = item_ff.blk >> cfg.bo;
                  for (int e = 0; e < STREAM_DEPTH; e++) begin
                     if (5'(e) < nd) begin
                        sa_in[sb][e] = (num + 32'(e + 1)) << cfg.bo;
                        sv_in[sb][e] = 1'b1;
                     end
                  end
                  pf_cnt_in = nd;
               end
               // touch the chosen buffer in the lru order
               st = sage_ff[sb];
               for (int i = 0; i < STREAMS; i++) begin
                  if ((5'(i) < ns) && (sage_ff[i] < st)) begin
                     sage_in[i] = sage_ff[i] + SB_W'(1);
                  end
               end
               sage_in[sb] = '0;
               shit_in     = found;
               pf_num_in   = num;
            end
            state_in = ST_WB;
         end
         ST_WB: begin
            if (!wb_ff) begin
               state_in = ST_DEM;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_WB;
               out_addr_in  = va_ff;
               out_ch_in    = 1'b0;
               out_sh_in    = 1'b0;
               out_last_in  = 1'b0;
               state_in     = ST_DEM;
            end
         end
         ST_DEM: begin
            if (!need_dem) begin
               state_in = ST_PF;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_DEMAND;
               out_addr_in  = item_ff.blk;
               out_ch_in    = 1'b0;
               out_sh_in    = 1'b0;
               out_last_in  = 1'b0;
               state_in     = ST_PF;
            end
         end
         ST_PF: begin
            if (pf_e_ff > pf_cnt_ff) begin
               state_in = ST_DONE;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_PREFETCH;
               out_addr_in  = (pf_num_ff + 32'(pf_e_ff)) << cfg.bo;
               out_ch_in    = 1'b0;
               out_sh_in    = 1'b0;
               out_last_in  = 1'b0;
               pf_e_in      = pf_e_ff + 5'd1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_DONE;
               out_addr_in  = '0;
               out_ch_in    = hit_ff;
               out_sh_in    = shit_ff;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_waddr] <= mem_wdata;
      end
      if (pop_ready && pop_valid) begin
         rd_ff <= row_mem[pop_data.set[SET_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int b = 0; b < STREAMS; b++) begin
            sage_ff[b] <= SB_W'(b);
            for (int e = 0; e < STREAM_DEPTH; e++) begin
               sa_ff[b][e] <= '0;
               sv_ff[b][e] <= 1'b0;
            end
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
         sage_ff      <= sage_in;
         sa_ff        <= sa_in;
         sv_ff        <= sv_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      hit_ff      <= hit_in;
      wb_ff       <= wb_in;
      va_ff       <= va_in;
      shit_ff     <= shit_in;
      pf_num_ff   <= pf_num_in;
      pf_cnt_ff   <= pf_cnt_in;
      pf_e_ff     <= pf_e_in;
      out_kind_ff <= out_kind_in;
      out_addr_ff <= out_addr_in;
      out_ch_ff   <= out_ch_in;
      out_sh_ff   <= out_sh_in;
      out_last_ff <= out_last_in;
   end

   `LWCSP_ASSERT_NEXT(a_eval_then_inv, state_ff == ST_EVAL, state_ff == ST_INV)
   `LWCSP_ASSERT_NEXT(a_done_returns_idle, (state_ff == ST_DONE) && out_free, state_ff == ST_IDLE)
   `LWCSP_ASSERT_IMP(a_flags_only_on_done, out_valid_ff && (out_kind_ff != KIND_DONE), !out_ch_ff && !out_sh_ff && !out_last_ff)
   `LWCSP_ASSERT_IMP(a_no_pop_while_clear, state_ff == ST_CLEAR, !pop_ready)

endmodule
`default_nettype wire

FILE: sv/lru_writeback_cache_stream_prefetch.sv
// channel   direction  payload
// req_      in         tdata: address; tuser: action
// rsp_      out        tdata: req_address; tuser: kind, cache_hit, stream_hit; tlast: last
// csr_      in/out     apb registers at 4*i: block_offset_bits, index_bits, ways_in_use,
//                      streams_in_use, stream_depth_in_use
// front: accept, multiply, scale for set index modulo sets, push; no new request until the push
// back: one state per step plus a prefetch step per prefetch issued; it sets
// the rate (pop and set read, tag eval, stream invalidate, stream lookup, then one
// step each for write-back, demand, prefetch end check and done)
// after reset a clearing pass writes every set in turn; requests wait.
// a stalled rsp side freezes the back; the front fills the two-entry queue then waits.
`default_nettype none
module lru_writeback_cache_stream_prefetch
   import lwcsp_pkg::*;
#(
   parameter int SETS         = 256,
   parameter int WAYS         = 4,
   parameter int STREAMS      = 4,
   parameter int STREAM_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] address
   input  wire logic [0:0]  req_tuser,   // [0] action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] req_address
   output logic [3:0]       rsp_tuser,   // [1:0] kind, [2] cache_hit, [3] stream_hit
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       cfg_we;

   item_type push_data, pop_data;
   logic     push_valid, push_ready, pop_valid, pop_ready;
   logic     clearing;
   kind_type rsp_kind;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_we) begin
         case (reg_idx)
            REG_BO:      cfg_in.bo      = csr_pwdata[2:0];
            REG_IB:      cfg_in.ib      = csr_pwdata[3:0];
            REG_WAYS:    cfg_in.ways    = csr_pwdata[2:0];
            REG_STREAMS: cfg_in.streams = csr_pwdata[2:0];
            REG_DEPTH:   cfg_in.depth   = csr_pwdata[2:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_BO:      csr_prdata = {29'd0, cfg_ff.bo};
         REG_IB:      csr_prdata = {28'd0, cfg_ff.ib};
         REG_WAYS:    csr_prdata = {29'd0, cfg_ff.ways};
         REG_STREAMS: csr_prdata = {29'd0, cfg_ff.streams};
         REG_DEPTH:   csr_prdata = {29'd0, cfg_ff.depth};
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bo      <= 3'd4;
         cfg_ff.ib      <= 4'd6;
         cfg_ff.ways    <= 3'd4;
         cfg_ff.streams <= 3'd0;
         cfg_ff.depth   <= 3'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lwcsp_front #(
      .SETS(SETS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .hold        (clearing),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_action  (req_tuser[0]),
      .req_address (req_tdata),
      .push_valid  (push_valid),
      .push_data   (push_data),
      .push_ready  (push_ready)
   );

   lwcsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   lwcsp_back #(
      .SETS         (SETS),
      .WAYS         (WAYS),
      .STREAMS      (STREAMS),
      .STREAM_DEPTH (STREAM_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .pop_valid      (pop_valid),
      .pop_data       (pop_data),
      .pop_ready      (pop_ready),
      .clearing       (clearing),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_kind       (rsp_kind),
      .rsp_address    (rsp_tdata),
      .rsp_cache_hit  (rsp_tuser[2]),
      .rsp_stream_hit (rsp_tuser[3]),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tuser[1:0] = rsp_kind;

endmodule
`default_nettype wire
